>>> rtl/line_follow_pid_drive_defines.svh
// ----------------------------------------------------------------------------
// line_follow_pid_drive_defines
// assertion macros shared by the line follower rtl
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOW_PID_DRIVE_DEFINES_SVH
`define LINE_FOLLOW_PID_DRIVE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LFPD_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, disabled while in reset
`define LFPD_ASSERT_NXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// types and fixed constants of the line follower pd drive
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  // field widths
  localparam int LIGHT_W = 12;
  localparam int PWM_W   = 8;
  localparam int CFG_W   = 12;
  localparam int NUM_CH  = 5;

  typedef logic [1:0] op_t;
  typedef logic [1:0] mode_t;
  typedef logic [1:0] cfg_idx_t;

  localparam op_t OP_FIRST_CAL = 2'd0;
  localparam op_t OP_CAL       = 2'd1;
  localparam op_t OP_END_CAL   = 2'd2;
  localparam op_t OP_RUN       = 2'd3;

  localparam mode_t MODE_STOP = 2'd0;
  localparam mode_t MODE_FWD  = 2'd1;
  localparam mode_t MODE_REV  = 2'd2;

  localparam cfg_idx_t CFG_BASE_SPEED = 2'd0;
  localparam cfg_idx_t CFG_LIGHT_REF  = 2'd1;
  localparam cfg_idx_t CFG_DER_RATIO  = 2'd2;

  // register reset values
  localparam logic [7:0]  BASE_SPEED_RST = 8'd240;
  localparam logic [11:0] LIGHT_REF_RST  = 12'd1000;
  localparam logic [5:0]  DER_RATIO_RST  = 6'd10;

  localparam int SPIN_SPEED = 200;

  // fixed steering gain is 3 / GAIN_DEN
  localparam int GAIN_DEN = 5000;

  // datapath widths
  localparam int ERR_W  = 13;  // channel difference and stored error
  localparam int KREF_W = 15;  // 3 * (reference - c3)
  localparam int MIX_W  = 22;  // (r+1)*e - r*prev
  localparam int PROD_W = KREF_W + MIX_W;

  // quotient is saturated; 4095 is beyond any base +/- pid that can still
  // change a clamped wheel speed for the whole pwm limit range
  localparam int Q_BITS    = 12;
  localparam int REM_W     = 25;
  localparam int SAT_LIM   = GAIN_DEN * (2 ** Q_BITS);

  // floor(n / GAIN_DEN) == (n * RECIP_M) >> RECIP_SH for every n below 2**REM_W
  localparam int RECIP_W  = 26;
  localparam int RECIP_SH = 38;
  localparam logic [RECIP_W-1:0] RECIP_M = 26'd54975582;

  // shared signed multiplier operand and product widths
  localparam int MUL_A_W = REM_W + 1;
  localparam int MUL_B_W = RECIP_W + 1;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // wheel sum width and width of the largest pwm limit
  localparam int SUM_W     = Q_BITS + 2;
  localparam int PWM_LIM_W = 10;

endpackage

`default_nettype wire

>>> rtl/line_follow_pid_drive.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive: five-channel line follower with pd steering
// a word is taken only while idle and finished before the next is taken; calibration, end and
// hard-turn words end in the decide step, a pd word runs mul1, mul2, mix, mul3, sat, div (skipped
// when the quotient saturates) and clamp with up to 4 passes of a shared multiplier; decide and clamp
// wait while the output register is full; rst (sync, high) clears config, thresholds and error
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_follow_pid_drive_defines.svh"

module line_follow_pid_drive #(
  parameter int ADC_BITS = 12,
  parameter int PWM_MAX  = 255
) (
  input  logic                          clk,
  input  logic                          rst,
  // input word channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lfpd_pkg::op_t                 op,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_0,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_1,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_2,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_3,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_4,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_5,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_6,
  input  logic [lfpd_pkg::LIGHT_W-1:0]  light_7,
  // result word channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lfpd_pkg::PWM_W-1:0]    left_pwm,
  output lfpd_pkg::mode_t               left_mode,
  output logic [lfpd_pkg::PWM_W-1:0]    right_pwm,
  output lfpd_pkg::mode_t               right_mode,
  // configuration write port
  input  logic                          cfg_wen,
  input  lfpd_pkg::cfg_idx_t            cfg_index,
  input  logic [lfpd_pkg::CFG_W-1:0]    cfg_data
);

  import lfpd_pkg::*;

  // effective sample width: low ADC_BITS of each 12 bit sample
  localparam int CH_W = (ADC_BITS < LIGHT_W) ? ADC_BITS : LIGHT_W;

  // spin duty and pwm limit in the widths they are used at
  localparam int SPIN_CAP = (SPIN_SPEED > PWM_MAX) ? PWM_MAX : SPIN_SPEED;
  localparam logic [PWM_W-1:0]            SPIN_PWM  = PWM_W'(SPIN_CAP);
  localparam logic [PWM_LIM_W-1:0]        PWM_MAX_V = PWM_LIM_W'(PWM_MAX);
  localparam logic signed [SUM_W-1:0]     PWM_MAX_S = SUM_W'(PWM_MAX);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_MUL1   = 4'd2;
  localparam logic [3:0] S_MUL2   = 4'd3;
  localparam logic [3:0] S_MIX    = 4'd4;
  localparam logic [3:0] S_MUL3   = 4'd5;
  localparam logic [3:0] S_SAT    = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_CLAMP  = 4'd8;

  // floor average of two channel values
  function automatic logic [CH_W-1:0] avg2(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b);
    logic [CH_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CH_W:1];
  endfunction

  // clamp a signed wheel sum to 0..PWM_MAX, keep the low pwm bits
  function automatic logic [PWM_W-1:0] clamp_pwm(input logic signed [SUM_W-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > PWM_MAX_S) begin
      return PWM_MAX_V[PWM_W-1:0];
    end else begin
      return v[PWM_W-1:0];
    end
  endfunction

  // control
  logic [3:0]                state;

  // configuration registers
  logic [7:0]                base_speed;
  logic [11:0]               light_reference;
  logic [5:0]                derivative_ratio;

  // channel values of the current word and calibration state
  op_t                       op_r;
  logic [CH_W-1:0]           chan_in   [NUM_CH];
  logic [CH_W-1:0]           chan      [NUM_CH];
  logic [CH_W-1:0]           ch_min    [NUM_CH];
  logic [CH_W-1:0]           ch_max    [NUM_CH];
  logic [CH_W-1:0]           ch_thr    [NUM_CH];
  logic signed [ERR_W-1:0]   last_error;

  // pd datapath
  logic signed [ERR_W-1:0]   err_in;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   kref;
  logic signed [KREF_W-1:0]  kref3_in;
  logic signed [KREF_W-1:0]  kref3;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [PROD_W-1:0]  prod;
  logic signed [MIX_W-1:0]   term;
  logic signed [MIX_W-1:0]   mix;
  logic [PROD_W-1:0]         mag;
  logic                      sat;
  logic                      neg;
  logic [REM_W-1:0]          rem;
  logic [Q_BITS-1:0]         quo;
  logic signed [SUM_W-1:0]   q_s;
  logic signed [SUM_W-1:0]   pid;
  logic signed [SUM_W-1:0]   base_s;
  logic signed [SUM_W-1:0]   left_v;
  logic signed [SUM_W-1:0]   right_v;
  logic [7:0]                base_cap;

  // decision and result staging
  logic                      out_free;
  logic                      decide_go;
  logic                      left_cross;
  logic                      right_cross;
  logic                      on_line;
  logic                      emit;
  logic [PWM_W-1:0]          emit_lp;
  logic [PWM_W-1:0]          emit_rp;
  mode_t                     emit_lm;
  mode_t                     emit_rm;

  // input word is taken only between items; a waiting result does not block
  assign in_ready = (state == S_IDLE);

  // the output register is free when empty or being drained this cycle
  assign out_free  = !out_valid || out_ready;
  assign decide_go = (state == S_DECIDE) && out_free;

  // eight samples folded into five channels
  always_comb begin
    chan_in[0] = avg2(light_0[CH_W-1:0], light_1[CH_W-1:0]);
    chan_in[1] = light_2[CH_W-1:0];
    chan_in[2] = avg2(light_3[CH_W-1:0], light_4[CH_W-1:0]);
    chan_in[3] = light_5[CH_W-1:0];
    chan_in[4] = avg2(light_6[CH_W-1:0], light_7[CH_W-1:0]);
  end

  // run-word tests against stored thresholds
  assign left_cross  = (chan[0] > ch_thr[0]) && (chan[4] < ch_thr[4]);
  assign right_cross = (chan[4] > ch_thr[4]) && (chan[0] < ch_thr[0]);
  assign on_line     = (chan[3] > ch_thr[3]);

  // steering error e = c2 - c4 and 3 * (reference - c3)
  assign err_in   = $signed({1'b0, LIGHT_W'(chan[2])}) - $signed({1'b0, LIGHT_W'(chan[4])});
  assign kref     = $signed({1'b0, light_reference}) - $signed({1'b0, LIGHT_W'(chan[3])});
  assign kref3_in = KREF_W'(kref) + (KREF_W'(kref) <<< 1);

  // base duty capped at the pwm limit
  assign base_cap = (PWM_LIM_W'(base_speed) > PWM_MAX_V) ? PWM_MAX_V[7:0] : base_speed;

  // shared multiplier: (r+1)*e, then r*prev, then 3*kref*mix, then the
  // magnitude times the reciprocal of the gain denominator
  always_comb begin
    case (state)
      S_MUL1: begin
        mul_a = $signed(MUL_A_W'(derivative_ratio) + MUL_A_W'(1));
        mul_b = MUL_B_W'(err);
      end
      S_MUL2: begin
        mul_a = $signed(MUL_A_W'(derivative_ratio));
        mul_b = MUL_B_W'(last_error);
      end
      S_MUL3: begin
        mul_a = MUL_A_W'(kref3);
        mul_b = MUL_B_W'(mix);
      end
      S_DIV: begin
        mul_a = $signed({1'b0, rem});
        mul_b = $signed({1'b0, RECIP_M});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // magnitude of the product and saturation of the quotient
  assign mag = $unsigned(prod[PROD_W-1] ? -prod : prod);
  assign sat = (mag >= PROD_W'(SAT_LIM));

  // signed pid (truncated toward zero) and the two wheel sums
  assign q_s     = $signed(SUM_W'(quo));
  assign pid     = neg ? -q_s : q_s;
  assign base_s  = $signed(SUM_W'(base_cap));
  assign left_v  = base_s - pid;
  assign right_v = base_s + pid;

  // result selection
  always_comb begin
    emit    = 1'b0;
    emit_lp = '0;
    emit_lm = MODE_STOP;
    emit_rp = '0;
    emit_rm = MODE_STOP;
    if (decide_go) begin
      case (op_r) inside
        OP_FIRST_CAL, OP_CAL: begin
          // spin in place while sweeping the sensors
          emit    = 1'b1;
          emit_lp = SPIN_PWM;
          emit_lm = MODE_FWD;
          emit_rp = SPIN_PWM;
          emit_rm = MODE_REV;
        end
        OP_END_CAL: begin
          emit = 1'b1;
        end
        default: begin
          if (left_cross) begin
            // line seen on the left only: hard left turn
            emit    = 1'b1;
            emit_rp = base_cap;
            emit_rm = MODE_FWD;
          end else if (right_cross) begin
            // line seen on the right only: hard right turn
            emit    = 1'b1;
            emit_lp = base_cap;
            emit_lm = MODE_FWD;
          end
        end
      endcase
    end else if ((state == S_CLAMP) && out_free) begin
      emit    = 1'b1;
      emit_lp = clamp_pwm(left_v);
      emit_lm = MODE_FWD;
      emit_rp = clamp_pwm(right_v);
      emit_rm = MODE_FWD;
    end
  end

  // sequencer, configuration and reset-cleared state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      base_speed       <= BASE_SPEED_RST;
      light_reference  <= LIGHT_REF_RST;
      derivative_ratio <= DER_RATIO_RST;
      last_error       <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        ch_thr[i] <= '0;
      end
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          CFG_BASE_SPEED: base_speed       <= cfg_data[7:0];
          CFG_LIGHT_REF:  light_reference  <= cfg_data[11:0];
          CFG_DER_RATIO:  derivative_ratio <= cfg_data[5:0];
          default: ;
        endcase
      end

      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            if (op_r == OP_END_CAL) begin
              // midpoint thresholds
              for (int i = 0; i < NUM_CH; i++) begin
                ch_thr[i] <= avg2(ch_min[i], ch_max[i]);
              end
            end
            if ((op_r == OP_RUN) && !left_cross && !right_cross && on_line) begin
              state <= S_MUL1;
            end else begin
              // done, with or without a result word
              state <= S_IDLE;
            end
          end
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_MIX;
        S_MIX:  state <= S_MUL3;
        S_MUL3: state <= S_SAT;
        S_SAT: begin
          if (sat) begin
            state <= S_CLAMP;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV:  state <= S_CLAMP;
        S_CLAMP: begin
          if (out_free) begin
            last_error <= err;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r <= op;
      for (int i = 0; i < NUM_CH; i++) begin
        chan[i] <= chan_in[i];
      end
    end

    if (decide_go) begin
      case (op_r)
        OP_FIRST_CAL: begin
          for (int i = 0; i < NUM_CH; i++) begin
            ch_min[i] <= chan[i];
            ch_max[i] <= chan[i];
          end
        end
        OP_CAL: begin
          for (int i = 0; i < NUM_CH; i++) begin
            if (chan[i] < ch_min[i]) ch_min[i] <= chan[i];
            if (chan[i] > ch_max[i]) ch_max[i] <= chan[i];
          end
        end
        default: ;
      endcase
      err   <= err_in;
      kref3 <= kref3_in;
    end

    case (state)
      S_MUL1: term <= mul_p[MIX_W-1:0];
      S_MUL2: prod <= mul_p[PROD_W-1:0];
      S_MIX:  mix  <= term - prod[MIX_W-1:0];
      S_MUL3: prod <= mul_p[PROD_W-1:0];
      S_SAT: begin
        neg <= prod[PROD_W-1];
        rem <= mag[REM_W-1:0];
        quo <= sat ? '1 : '0;
      end
      // quotient by reciprocal multiplication, exact below the saturation limit
      S_DIV:  quo <= mul_p[RECIP_SH +: Q_BITS];
      default: ;
    endcase

    if (emit) begin
      left_pwm   <= emit_lp;
      left_mode  <= emit_lm;
      right_pwm  <= emit_rp;
      right_mode <= emit_rm;
    end
  end

  // an accepted word always goes to the decode step next
  `LFPD_ASSERT_NXT(a_accept_decide, in_valid && in_ready, state == S_DECIDE, "word skipped decode")
  // the divide step only sees magnitudes below the saturation limit
  `LFPD_ASSERT_IMP(a_div_range, state == S_DIV, rem < REM_W'(SAT_LIM), "divide operand too big")
  // a stopped left wheel has zero duty and the right wheel never reverses then
  `LFPD_ASSERT_IMP(a_left_stop, out_valid && (left_mode == MODE_STOP), (left_pwm == '0) && (right_mode != MODE_REV), "left stop word inconsistent")

endmodule

`default_nettype wire

>>> sim/line_follow_pid_drive_checker.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive_checker
// watches the word channels and config port, predicts wheel commands and
// compares each result word against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pid_drive_checker
  import lfpd_pkg::*;
#(
  parameter int PWM_MAX = 255
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_ready,
  input  wire op_t                  op,
  input  wire logic [LIGHT_W-1:0]   light_0,
  input  wire logic [LIGHT_W-1:0]   light_1,
  input  wire logic [LIGHT_W-1:0]   light_2,
  input  wire logic [LIGHT_W-1:0]   light_3,
  input  wire logic [LIGHT_W-1:0]   light_4,
  input  wire logic [LIGHT_W-1:0]   light_5,
  input  wire logic [LIGHT_W-1:0]   light_6,
  input  wire logic [LIGHT_W-1:0]   light_7,
  input  wire logic                 out_valid,
  input  wire logic                 out_ready,
  input  wire logic [PWM_W-1:0]     left_pwm,
  input  wire mode_t                left_mode,
  input  wire logic [PWM_W-1:0]     right_pwm,
  input  wire mode_t                right_mode,
  input  wire logic                 cfg_wen,
  input  wire cfg_idx_t             cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        pending,
  output int                        mismatch_count
);

  localparam int GAIN_NUM = 3;

  typedef struct packed {
    logic [PWM_W-1:0] left_pwm;
    mode_t            left_mode;
    logic [PWM_W-1:0] right_pwm;
    mode_t            right_mode;
  } wheel_cmd_t;

  typedef logic [LIGHT_W-1:0] frame_t [8];

  // own copy of config and steering state
  logic [7:0]         base_speed;
  logic [11:0]        light_ref;
  logic [5:0]         der_ratio;
  logic [LIGHT_W-1:0] ch_min [NUM_CH];
  logic [LIGHT_W-1:0] ch_max [NUM_CH];
  logic [LIGHT_W-1:0] ch_thr [NUM_CH];
  int                 prev_error;

  wheel_cmd_t wheel_queue [$];

  initial begin
    pending = 0;
    mismatch_count = 0;
  end

  function automatic logic [PWM_W-1:0] sat_pwm(input longint v);
    if (v < 0) return '0;
    if (v > PWM_MAX) return PWM_W'(PWM_MAX);
    return PWM_W'(v);
  endfunction

  function automatic bit predict_wheels(input op_t o, input frame_t s, output wheel_cmd_t w);
    logic [LIGHT_W:0]   pair_sum [3];
    logic [LIGHT_W:0]   mid_sum;
    logic [LIGHT_W-1:0] ch [NUM_CH];
    logic [PWM_W-1:0]   spin;
    logic [PWM_W-1:0]   base;
    int                 e;
    int                 kref;
    int                 mix;
    longint             pid;
    pair_sum[0] = s[0] + s[1];
    pair_sum[1] = s[3] + s[4];
    pair_sum[2] = s[6] + s[7];
    ch[0] = pair_sum[0][LIGHT_W:1];
    ch[1] = s[2];
    ch[2] = pair_sum[1][LIGHT_W:1];
    ch[3] = s[5];
    ch[4] = pair_sum[2][LIGHT_W:1];
    spin = sat_pwm(SPIN_SPEED);
    base = sat_pwm(base_speed);
    w = '0;
    predict_wheels = 1'b1;
    case (o)
      OP_FIRST_CAL: begin
        for (int i = 0; i < NUM_CH; i++) begin
          ch_min[i] = ch[i];
          ch_max[i] = ch[i];
        end
        w = '{spin, MODE_FWD, spin, MODE_REV};
      end
      OP_CAL: begin
        for (int i = 0; i < NUM_CH; i++) begin
          if (ch[i] < ch_min[i]) ch_min[i] = ch[i];
          if (ch[i] > ch_max[i]) ch_max[i] = ch[i];
        end
        w = '{spin, MODE_FWD, spin, MODE_REV};
      end
      OP_END_CAL: begin
        for (int i = 0; i < NUM_CH; i++) begin
          mid_sum = ch_min[i] + ch_max[i];
          ch_thr[i] = mid_sum[LIGHT_W:1];
        end
        w = '{8'd0, MODE_STOP, 8'd0, MODE_STOP};
      end
      default: begin
        if (ch[0] > ch_thr[0] && ch[4] < ch_thr[4]) begin
          w = '{8'd0, MODE_STOP, base, MODE_FWD};
        end else if (ch[4] > ch_thr[4] && ch[0] < ch_thr[0]) begin
          w = '{base, MODE_FWD, 8'd0, MODE_STOP};
        end else if (ch[3] > ch_thr[3]) begin
          // pd law, exact integer form of the 0.0006 gain
          e    = int'(ch[2]) - int'(ch[4]);
          kref = int'(light_ref) - int'(ch[3]);
          mix  = (int'(der_ratio) + 1) * e - int'(der_ratio) * prev_error;
          pid  = (longint'(kref) * longint'(mix) * GAIN_NUM) / GAIN_DEN;
          prev_error = e;
          w = '{sat_pwm(longint'(base) - pid), MODE_FWD,
                sat_pwm(longint'(base) + pid), MODE_FWD};
        end else begin
          predict_wheels = 1'b0;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    wheel_cmd_t got;
    wheel_cmd_t want;
    frame_t     frame;
    if (rst) begin
      base_speed = BASE_SPEED_RST;
      light_ref  = LIGHT_REF_RST;
      der_ratio  = DER_RATIO_RST;
      for (int i = 0; i < NUM_CH; i++) begin
        ch_min[i] = '0;
        ch_max[i] = '0;
        ch_thr[i] = '0;
      end
      prev_error = 0;
      wheel_queue.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_BASE_SPEED: base_speed = cfg_data[7:0];
          CFG_LIGHT_REF:  light_ref  = cfg_data[11:0];
          CFG_DER_RATIO:  der_ratio  = cfg_data[5:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{left_pwm, left_mode, right_pwm, right_mode};
        if (wheel_queue.size() == 0) begin
          $error("unexpected result word: left_pwm %0d left_mode %0d right_pwm %0d right_mode %0d",
                 got.left_pwm, got.left_mode, got.right_pwm, got.right_mode);
          mismatch_count++;
        end else begin
          want = wheel_queue.pop_front();
          if (got != want) mismatch_count++;
          if (got.left_pwm != want.left_pwm)
            $error("left_pwm: expected %0d, actual %0d", want.left_pwm, got.left_pwm);
          if (got.left_mode != want.left_mode)
            $error("left_mode: expected %0d, actual %0d", want.left_mode, got.left_mode);
          if (got.right_pwm != want.right_pwm)
            $error("right_pwm: expected %0d, actual %0d", want.right_pwm, got.right_pwm);
          if (got.right_mode != want.right_mode)
            $error("right_mode: expected %0d, actual %0d", want.right_mode, got.right_mode);
        end
      end
      if (in_valid && in_ready) begin
        frame = '{light_0, light_1, light_2, light_3, light_4, light_5, light_6, light_7};
        if (predict_wheels(op, frame, want)) wheel_queue.push_back(want);
      end
    end
    pending = wheel_queue.size();
  end

endmodule

`default_nettype wire

>>> sim/line_follow_pid_drive_tb.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive_tb
// regression of the line follower pd drive: directed corner words, then
// calibrate-and-run sequences with random content over several register
// settings and idling phases; a side checker predicts and compares results
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_pid_drive_tb;
  import lfpd_pkg::*;

  // quiet cycles before a config write: a run word that gives no result
  // leaves nothing to wait on in the checker
  localparam int CFG_GUARD   = 24;
  localparam int END_GUARD   = 40;
  localparam int PHASE_WORDS = 235;
  localparam int NUM_PHASES  = 8;

  typedef logic [LIGHT_W-1:0] frame_t [8];

  // level bands for a sensor sample
  typedef enum int {BAND_ANY, BAND_LOW, BAND_HIGH, BAND_RAIL} band_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  op_t                  op = OP_FIRST_CAL;
  logic [LIGHT_W-1:0]   light_0 = '0;
  logic [LIGHT_W-1:0]   light_1 = '0;
  logic [LIGHT_W-1:0]   light_2 = '0;
  logic [LIGHT_W-1:0]   light_3 = '0;
  logic [LIGHT_W-1:0]   light_4 = '0;
  logic [LIGHT_W-1:0]   light_5 = '0;
  logic [LIGHT_W-1:0]   light_6 = '0;
  logic [LIGHT_W-1:0]   light_7 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PWM_W-1:0]     left_pwm;
  mode_t                left_mode;
  logic [PWM_W-1:0]     right_pwm;
  mode_t                right_mode;
  logic                 cfg_wen = 1'b0;
  cfg_idx_t             cfg_index = CFG_BASE_SPEED;
  logic [CFG_W-1:0]     cfg_data = '0;

  int pending;
  int mismatch_count;
  int words_sent = 0;

  // idle chance in percent for each side, changed per phase
  int send_pct = 0;
  int recv_pct = 0;

  always #2 clk = ~clk;

  line_follow_pid_drive i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .light_0    (light_0),
    .light_1    (light_1),
    .light_2    (light_2),
    .light_3    (light_3),
    .light_4    (light_4),
    .light_5    (light_5),
    .light_6    (light_6),
    .light_7    (light_7),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .left_pwm   (left_pwm),
    .left_mode  (left_mode),
    .right_pwm  (right_pwm),
    .right_mode (right_mode),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  line_follow_pid_drive_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .op             (op),
    .light_0        (light_0),
    .light_1        (light_1),
    .light_2        (light_2),
    .light_3        (light_3),
    .light_4        (light_4),
    .light_5        (light_5),
    .light_6        (light_6),
    .light_7        (light_7),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .left_pwm       (left_pwm),
    .left_mode      (left_mode),
    .right_pwm      (right_pwm),
    .right_mode     (right_mode),
    .cfg_wen        (cfg_wen),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending        (pending),
    .mismatch_count (mismatch_count)
  );

  // result side: random stalls at the phase's rate, one update per edge
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #4000000;
    $display("line_follow_pid_drive regression: fail");
    $finish;
  end

  function automatic logic [LIGHT_W-1:0] pick_level(input band_t b);
    case (b)
      BAND_LOW:  return LIGHT_W'($urandom_range(0, 1000));
      BAND_HIGH: return LIGHT_W'($urandom_range(3000, 4095));
      BAND_RAIL: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default:   return LIGHT_W'($urandom_range(0, 4095));
    endcase
  endfunction

  // bands per channel: c0 pair, c1, c2 pair, c3, c4 pair
  function automatic frame_t make_frame(input band_t b0, input band_t b1, input band_t b2,
                                        input band_t b3, input band_t b4);
    frame_t s;
    s[0] = pick_level(b0);
    s[1] = pick_level(b0);
    s[2] = pick_level(b1);
    s[3] = pick_level(b2);
    s[4] = pick_level(b2);
    s[5] = pick_level(b3);
    s[6] = pick_level(b4);
    s[7] = pick_level(b4);
    return s;
  endfunction

  function automatic band_t any_band();
    return band_t'($urandom_range(0, 3));
  endfunction

  // valid stays up between back-to-back words; it only drops for a gap
  task automatic send_word(input op_t o, input frame_t s);
    if ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    light_0  <= s[0];
    light_1  <= s[1];
    light_2  <= s[2];
    light_3  <= s[3];
    light_4  <= s[4];
    light_5  <= s[5];
    light_6  <= s[6];
    light_7  <= s[7];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // hold off the sender until every predicted word is back, then pad
  task automatic wait_settled(input int pad);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (pad) @(posedge clk);
  endtask

  // upper data bits beyond a register's width are junk on purpose
  task automatic write_config(input logic [7:0] base, input logic [11:0] lref,
                              input logic [5:0] ratio);
    logic [3:0] junk_b;
    logic [5:0] junk_r;
    junk_b = 4'($urandom_range(0, 15));
    junk_r = 6'($urandom_range(0, 63));
    wait_settled(CFG_GUARD);
    cfg_wen   <= 1'b1;
    cfg_index <= CFG_BASE_SPEED;
    cfg_data  <= {junk_b, base};
    @(posedge clk);
    cfg_index <= CFG_LIGHT_REF;
    cfg_data  <= lref;
    @(posedge clk);
    cfg_index <= CFG_DER_RATIO;
    cfg_data  <= {junk_r, ratio};
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    frame_t s;
    int     start_count;
    int     n;
    int     kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed words, reset register values, no idling ----

    // run before calibration: thresholds are zero, only the on-line test
    // can fire, so all-dark gives nothing and any c3 gives a pd word
    s = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_word(OP_RUN, s);
    s = '{0, 0, 0, 0, 0, 1, 0, 0};
    send_word(OP_RUN, s);
    // full positive error, large negative gain factor: wheels saturate
    s = '{0, 0, 0, 4095, 4095, 4095, 0, 0};
    send_word(OP_RUN, s);
    // full negative error against a full positive previous error
    s = '{0, 0, 0, 0, 0, 4095, 4095, 4095};
    send_word(OP_RUN, s);

    // calibrate from all dark to all bright, floor halving on odd sums
    s = '{0, 0, 0, 0, 0, 0, 0, 0};
    send_word(OP_FIRST_CAL, s);
    s = '{4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095};
    send_word(OP_CAL, s);
    s = '{1, 0, 12'h555, 12'haaa, 12'h555, 12'haaa, 12'h555, 12'haaa};
    send_word(OP_CAL, s);
    // thresholds all 2047
    s = '{12'h3c3, 12'hc3c, 7, 8, 9, 10, 11, 12};
    send_word(OP_END_CAL, s);

    // left crossing and right crossing
    s = '{4095, 4095, 0, 0, 0, 0, 0, 0};
    send_word(OP_RUN, s);
    s = '{0, 0, 0, 0, 0, 0, 4095, 4095};
    send_word(OP_RUN, s);
    // c0 just above, c4 just below: 4096/2 and 4093/2
    s = '{4095, 1, 0, 0, 0, 0, 4093, 0};
    send_word(OP_RUN, s);
    // c0 and c4 on their thresholds: falls through to the on-line test
    s = '{2047, 2047, 0, 4095, 4095, 4095, 2047, 2047};
    send_word(OP_RUN, s);
    // c3 equal to its threshold: no result
    s = '{2047, 2047, 0, 0, 0, 2047, 2047, 2047};
    send_word(OP_RUN, s);
    // both outer channels high, c3 dark: no result
    s = '{4095, 4095, 0, 0, 0, 0, 4095, 4095};
    send_word(OP_RUN, s);
    // c3 just over threshold, small error
    s = '{2047, 2047, 0, 2050, 2049, 2048, 2047, 2047};
    send_word(OP_RUN, s);
    // c3 above the reference: negative gain factor
    s = '{2047, 2047, 0, 100, 0, 2100, 2047, 2047};
    send_word(OP_RUN, s);

    // sender holds off until every result is back
    wait_settled(0);

    // ---- random phases: register sets and idling patterns ----
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ;  // reset register values
        1: write_config(8'd255, 12'd4095, 6'd63);
        2: write_config(8'd0, 12'd0, 6'd0);
        3: write_config(8'd128, 12'd2048, 6'd1);
        default: write_config(8'($urandom_range(0, 255)), 12'($urandom_range(0, 4095)),
                              6'($urandom_range(0, 63)));
      endcase

      // no idling, sender gaps, receiver stalls, both
      case (phase % 4)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 49;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 49;
        end
        default: begin
          send_pct = 30;
          recv_pct = 30;
        end
      endcase

      start_count = words_sent;
      while (words_sent - start_count < PHASE_WORDS) begin
        if ($urandom_range(0, 99) < 80) begin
          // well formed: first frame, tracking frames, end, then run frames
          s = make_frame(any_band(), any_band(), any_band(), any_band(), any_band());
          send_word(OP_FIRST_CAL, s);
          n = $urandom_range(1, 6);
          repeat (n) begin
            s = make_frame(any_band(), any_band(), any_band(), any_band(), any_band());
            send_word(OP_CAL, s);
          end
          s = make_frame(BAND_ANY, BAND_ANY, BAND_ANY, BAND_ANY, BAND_ANY);
          send_word(OP_END_CAL, s);
          n = $urandom_range(5, 30);
          repeat (n) begin
            kind = $urandom_range(0, 4);
            case (kind)
              0: s = make_frame(BAND_HIGH, BAND_ANY, BAND_ANY, BAND_ANY, BAND_LOW);
              1: s = make_frame(BAND_LOW, BAND_ANY, BAND_ANY, BAND_ANY, BAND_HIGH);
              2: s = make_frame(any_band(), BAND_ANY, any_band(), BAND_HIGH, any_band());
              3: s = make_frame(BAND_LOW, BAND_ANY, BAND_ANY, BAND_LOW, BAND_LOW);
              default: s = make_frame(BAND_ANY, BAND_ANY, BAND_ANY, BAND_ANY, BAND_ANY);
            endcase
            send_word(OP_RUN, s);
          end
        end else begin
          // noise: any op in any order, raw content
          n = $urandom_range(1, 4);
          repeat (n) begin
            s = make_frame(BAND_ANY, BAND_ANY, BAND_ANY, BAND_ANY, BAND_ANY);
            send_word(op_t'($urandom_range(0, 3)), s);
          end
        end
        // occasional full drain mid phase
        if ($urandom_range(0, 9) == 0) wait_settled(0);
      end
    end

    // drain and let any late word show up before the verdict
    wait_settled(END_GUARD);
    if (mismatch_count == 0) begin
      $display("line_follow_pid_drive regression: pass");
    end else begin
      $display("line_follow_pid_drive regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
